/* rtl/core/u8dw_pkg.sv */
`timescale 1ns / 1ps

package u8dw_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } byte_req_t;

  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  function automatic logic is_wide(input logic [20:0] cp);
    is_wide = cp inside {[21'h01100 : 21'h0115F], [21'h02E80 : 21'h0A4CF],
                         [21'h0AC00 : 21'h0D7A3], [21'h0F900 : 21'h0FAFF],
                         [21'h0FE30 : 21'h0FE6F], [21'h0FF00 : 21'h0FF60],
                         [21'h0FFE0 : 21'h0FFE6], [21'h20000 : 21'h3FFFD]};
  endfunction

endpackage

/* rtl/core/u8dw_in_stage.sv */
`timescale 1ns / 1ps

module u8dw_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_text_byte,
  input  logic                in_end_of_text,
  input  logic                out_free,
  output logic                req_take,
  output u8dw_pkg::byte_req_t req
);

  logic                s1_valid_r, s1_valid_nxt;
  u8dw_pkg::byte_req_t s1_req_r;
  logic                accept;

  assign req_take = s1_valid_r && (!s1_req_r.end_of_text || out_free);
  assign in_stall = s1_valid_r && !req_take;
  assign accept   = in_valid && !in_stall;
  assign req      = s1_req_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (req_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r.text_byte   <= in_text_byte;
      s1_req_r.end_of_text <= in_end_of_text;
    end
  end

endmodule

/* rtl/core/u8dw_scan.sv */
`timescale 1ns / 1ps

module u8dw_scan #(
  parameter int WIDTH_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_take,
  input  u8dw_pkg::byte_req_t req,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_total_width
);

  logic [20:0]           code_accum_r, code_accum_nxt;
  logic [1:0]            bytes_held_r, bytes_held_nxt;
  logic [2:0]            seq_length_r, seq_length_nxt;
  logic                  second_lead_r, second_lead_nxt;
  logic [WIDTH_BITS-1:0] running_r, running_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [15:0]           total_r;

  logic [7:0]            b;
  logic [20:0]           acc_shift;
  logic [2:0]            held_inc;
  logic [1:0]            after;
  logic [1:0]            add_amt;
  logic [WIDTH_BITS:0]   sum;
  logic [WIDTH_BITS-1:0] sat;
  logic [WIDTH_BITS+15:0] sat_ext;

  assign b         = req.text_byte;
  assign acc_shift = {code_accum_r[14:0], b[5:0]};
  assign held_inc  = {1'b0, bytes_held_r} + 3'd1;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    code_accum_nxt  = code_accum_r;
    bytes_held_nxt  = bytes_held_r;
    seq_length_nxt  = seq_length_r;
    second_lead_nxt = second_lead_r;
    add_amt         = 2'd0;
    after           = 2'd0;

    if (seq_length_r == u8dw_pkg::SEQ_NONE) begin
      if (!b[7]) begin
        add_amt = 2'd1;
      end else if (b[7:5] == u8dw_pkg::LEAD2_TAG) begin
        seq_length_nxt = u8dw_pkg::SEQ_TWO;
        bytes_held_nxt = 2'd1;
        code_accum_nxt = {16'd0, b[4:0]};
      end else if (b[7:4] == u8dw_pkg::LEAD3_TAG) begin
        seq_length_nxt = u8dw_pkg::SEQ_THREE;
        bytes_held_nxt = 2'd1;
        code_accum_nxt = {17'd0, b[3:0]};
      end else if (b[7:3] == u8dw_pkg::LEAD4_TAG) begin
        seq_length_nxt = u8dw_pkg::SEQ_FOUR;
        bytes_held_nxt = 2'd1;
        code_accum_nxt = {18'd0, b[2:0]};
      end else begin
        add_amt = 2'd1;
      end
    end else begin
      code_accum_nxt = acc_shift;
      if (held_inc == 3'd2) begin
        second_lead_nxt = (b[7:5] == u8dw_pkg::LEAD2_TAG);
      end
      if (held_inc >= seq_length_r) begin
        add_amt         = u8dw_pkg::is_wide(acc_shift) ? 2'd2 : 2'd1;
        code_accum_nxt  = '0;
        bytes_held_nxt  = '0;
        seq_length_nxt  = u8dw_pkg::SEQ_NONE;
        second_lead_nxt = 1'b0;
      end else begin
        bytes_held_nxt = held_inc[1:0];
      end
    end

    // a sequence cut short: lead counts 1, the rest is rescanned
    if (req.end_of_text && seq_length_nxt != u8dw_pkg::SEQ_NONE) begin
      after = bytes_held_nxt - 2'd1;
      case (after)
        2'd0:    add_amt = 2'd1;
        2'd1:    add_amt = 2'd2;
        default: add_amt = second_lead_nxt ? 2'd2 : 2'd3;
      endcase
    end
  end

  assign sum     = {1'b0, running_r} + {{(WIDTH_BITS-1){1'b0}}, add_amt};
  assign sat     = sum[WIDTH_BITS] ? {WIDTH_BITS{1'b1}} : sum[WIDTH_BITS-1:0];
  assign sat_ext = {16'd0, sat};

  always_comb begin
    running_nxt   = running_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (req_take) begin
      running_nxt = sat;
      if (req.end_of_text) begin
        running_nxt   = '0;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_accum_r  <= '0;
      bytes_held_r  <= '0;
      seq_length_r  <= u8dw_pkg::SEQ_NONE;
      second_lead_r <= 1'b0;
      running_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      running_r   <= running_nxt;
      if (req_take) begin
        if (req.end_of_text) begin
          code_accum_r  <= '0;
          bytes_held_r  <= '0;
          seq_length_r  <= u8dw_pkg::SEQ_NONE;
          second_lead_r <= 1'b0;
        end else begin
          code_accum_r  <= code_accum_nxt;
          bytes_held_r  <= bytes_held_nxt;
          seq_length_r  <= seq_length_nxt;
          second_lead_r <= second_lead_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take && req.end_of_text) begin
      total_r <= sat_ext[15:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_total_width = total_r;

endmodule

/* rtl/core/utf8_display_width.sv */
`timescale 1ns / 1ps

// Terminal column width of a UTF-8 string.
// Input channel: one byte per request (in_text_byte) with in_end_of_text set
// on the final byte. A request is taken when in_valid is high and in_stall low.
// Result channel: one request per string carrying out_total_width, taken when
// out_valid is high and out_stall low. Nothing is sent for non-final bytes.
// Throughput: one byte per cycle, sustained, including across string ends,
// as long as the receiver keeps up; the per-byte decode and width add is a
// single register stage.
// Result path: the final byte sits in the input register, then scan/accumulate
// loads the result register and raises out_valid.
// The running count saturates at 2**WIDTH_BITS-1; the low 16 bits are sent.
// When the receiver stalls, the result holds; bytes of the next string keep
// flowing, and only a further final byte waits in the input register, which
// raises in_stall until the pending result is taken.
// Reset (rst_n low, synchronous) clears the decode state, the running count
// and both valid flags.
module utf8_display_width #(
  parameter int WIDTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_total_width
);

  u8dw_pkg::byte_req_t req;
  logic                req_take;
  logic                out_free;

  u8dw_in_stage u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .out_free       (out_free),
    .req_take       (req_take),
    .req            (req)
  );

  u8dw_scan #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_scan (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_take        (req_take),
    .req             (req),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_total_width (out_total_width)
  );

endmodule
